// ----- design/stt_pkg.sv -----
`default_nettype none

package stt_pkg;

  // token kinds as carried in the result item
  typedef enum logic [2:0] {
    KIND_OPERATOR   = 3'd0,
    KIND_SEPARATOR  = 3'd1,
    KIND_INTEGER    = 3'd2,
    KIND_KEYWORD    = 3'd3,
    KIND_IDENTIFIER = 3'd4,
    KIND_END        = 3'd5
  } token_kind_t;

  // scanner state, one-hot
  typedef enum logic [3:0] {
    MODE_IDLE    = 4'b0001,
    MODE_COMMENT = 4'b0010,
    MODE_INT     = 4'b0100,
    MODE_WORD    = 4'b1000
  } scan_mode_t;

  // one token, last flag on top so the low 64 bits are the stream payload
  typedef struct packed {
    logic        last_of_run;
    logic [4:0]  keyword_index;
    logic [15:0] token_length;
    logic [31:0] start_position;
    logic [7:0]  first_char;
    token_kind_t token_kind;
  } token_t;

  localparam int TOKEN_DATA_W   = 64;
  localparam int KW_TABLE_DEPTH = 32;
  localparam int KW_TEXT_MAX    = 8;

  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DOLLAR = 8'h24;

  // keyword text, first character in the most significant used byte
  typedef struct packed {
    logic [3:0]  len;
    logic [63:0] text;
  } keyword_t;

  function automatic keyword_t kw_entry(input logic [4:0] idx);
    keyword_t k;
    k = '0;
    case (idx)
      5'd0:  begin k.len = 4'd3; k.text = 64'("int");      end
      5'd1:  begin k.len = 4'd5; k.text = 64'("float");    end
      5'd2:  begin k.len = 4'd4; k.text = 64'("bool");     end
      5'd3:  begin k.len = 4'd4; k.text = 64'("true");     end
      5'd4:  begin k.len = 4'd5; k.text = 64'("false");    end
      5'd5:  begin k.len = 4'd2; k.text = 64'("if");       end
      5'd6:  begin k.len = 4'd4; k.text = 64'("else");     end
      5'd7:  begin k.len = 4'd4; k.text = 64'("then");     end
      5'd8:  begin k.len = 4'd5; k.text = 64'("endif");    end
      5'd9:  begin k.len = 4'd5; k.text = 64'("while");    end
      5'd10: begin k.len = 4'd8; k.text = 64'("whilened"); end
      5'd11: begin k.len = 4'd2; k.text = 64'("do");       end
      5'd12: begin k.len = 4'd5; k.text = 64'("doend");    end
      5'd13: begin k.len = 4'd3; k.text = 64'("for");      end
      5'd14: begin k.len = 4'd6; k.text = 64'("forend");   end
      5'd15: begin k.len = 4'd5; k.text = 64'("input");    end
      5'd16: begin k.len = 4'd6; k.text = 64'("output");   end
      5'd17: begin k.len = 4'd3; k.text = 64'("and");      end
      5'd18: begin k.len = 4'd2; k.text = 64'("or");       end
      5'd19: begin k.len = 4'd3; k.text = 64'("not");      end
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return b inside {8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d};
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return b inside {[8'h61:8'h7a], [8'h41:8'h5a]};
  endfunction

  // = * + - / > < %
  function automatic logic is_operator(input logic [7:0] b);
    return b inside {8'h3d, 8'h2a, 8'h2b, 8'h2d, 8'h2f, 8'h3e, 8'h3c, 8'h25};
  endfunction

  // ( ) ; { } [ ] , . :
  function automatic logic is_separator(input logic [7:0] b);
    return b inside {8'h28, 8'h29, 8'h3b, 8'h7b, 8'h7d, 8'h5b, 8'h5d, 8'h2c, 8'h2e, 8'h3a};
  endfunction

endpackage

`default_nettype wire

// ----- design/source_text_tokenizer_unit.sv -----
`default_nettype none

// Source text tokenizer: takes one source byte per item on s_axis (tlast marks
// end of input, its data byte is ignored) and returns tokens on m_axis.
// Blanks are skipped, text between two '!' marks is a comment, operator and
// separator bytes give one-byte tokens, digit runs give integers and other
// runs give keywords or identifiers; end of input flushes the open token and
// adds an END token. A byte is taken every cycle while m_axis keeps up; a byte
// that both closes a pending token and yields a token of its own produces two
// results; the two-entry result buffer drains one token per cycle through the
// single output port while m_axis_tready is high, so s_axis_tready stays low
// while the second token waits. Keyword matching compares the pending word
// against the whole table at once. A byte's first token shows in the next cycle.
module source_text_tokenizer_unit #(
  parameter int KEYWORD_MAX_LEN = 8,
  parameter int KEYWORD_COUNT   = 20
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // text_byte
  input  wire logic        s_axis_tlast,   // end_of_input
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // token_kind[2:0], first_char[10:3], start_position[42:11],
  // token_length[58:43], keyword_index[63:59]
  output      logic [stt_pkg::TOKEN_DATA_W-1:0] m_axis_tdata,
  output      logic        m_axis_tlast    // last_of_run
);

  import stt_pkg::*;

  localparam int IDX_W  = (KEYWORD_MAX_LEN > 1) ? $clog2(KEYWORD_MAX_LEN) : 1;
  localparam int KW_CMP = (KEYWORD_MAX_LEN < KW_TEXT_MAX) ? KEYWORD_MAX_LEN : KW_TEXT_MAX;
  localparam int KW_N   = (KEYWORD_COUNT < KW_TABLE_DEPTH) ? KEYWORD_COUNT : KW_TABLE_DEPTH;

  // scanner state
  scan_mode_t  scan_mode, scan_mode_next;
  logic [7:0]  word_chars [KEYWORD_MAX_LEN];
  logic [7:0]  word_chars_next [KEYWORD_MAX_LEN];
  logic [15:0] pending_length, pending_length_next;
  logic [31:0] pending_start, pending_start_next;
  logic [7:0]  pending_first, pending_first_next;
  logic [31:0] byte_position, byte_position_next;

  // result buffer, head in slot 0
  token_t res0, res1;
  logic   res0_valid, res1_valid;

  logic   in_accept, out_accept;
  logic   kw_hit;
  logic [4:0] kw_idx;
  logic   flushing;
  token_t flush_tok, tok_a, tok_b, new0, new1;
  logic   valid_a, valid_b, scan_fresh;
  logic [7:0] b;

  assign in_accept  = s_axis_tvalid && s_axis_tready;
  assign out_accept = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = !res1_valid && (!res0_valid || m_axis_tready);
  assign m_axis_tvalid = res0_valid;
  assign m_axis_tdata  = res0[TOKEN_DATA_W-1:0];
  assign m_axis_tlast  = res0.last_of_run;
  assign b = s_axis_tdata;

  // keyword match against the whole table, lowest index wins
  always_comb begin
    keyword_t k;
    logic     m;
    kw_hit = 1'b0;
    kw_idx = '0;
    for (int i = KW_N - 1; i >= 0; i--) begin
      k = kw_entry(5'(i));
      m = (k.len != 4'd0) && (pending_length == 16'(k.len))
          && (pending_length <= 16'(KEYWORD_MAX_LEN));
      for (int j = 0; j < KW_CMP; j++) begin
        if (j < int'(k.len)) begin
          m = m && (word_chars[j] == k.text[8*(int'(k.len)-1-j) +: 8]);
        end
      end
      if (m) begin
        kw_hit = 1'b1;
        kw_idx = 5'(i);
      end
    end
  end

  // token of the pending integer or word
  always_comb begin
    flushing = (scan_mode == MODE_INT) || (scan_mode == MODE_WORD);
    flush_tok = '0;
    flush_tok.first_char     = pending_first;
    flush_tok.start_position = pending_start;
    flush_tok.token_length   = pending_length;
    if (scan_mode == MODE_INT) begin
      flush_tok.token_kind = KIND_INTEGER;
    end else if (kw_hit) begin
      flush_tok.token_kind    = KIND_KEYWORD;
      flush_tok.keyword_index = kw_idx;
    end else begin
      flush_tok.token_kind = KIND_IDENTIFIER;
    end
  end

  // next state and the tokens caused by the incoming item
  always_comb begin
    scan_mode_next      = scan_mode;
    word_chars_next     = word_chars;
    pending_length_next = pending_length;
    pending_start_next  = pending_start;
    pending_first_next  = pending_first;
    byte_position_next  = byte_position;
    valid_a    = 1'b0;
    valid_b    = 1'b0;
    tok_a      = flush_tok;
    tok_b      = '0;
    scan_fresh = 1'b0;

    if (s_axis_tlast) begin
      // end of input: flush, then END at the current offset
      valid_a        = flushing;
      scan_mode_next = MODE_IDLE;
      valid_b        = 1'b1;
      tok_b.token_kind     = KIND_END;
      tok_b.start_position = byte_position;
    end else begin
      byte_position_next = byte_position + 32'd1;
      case (scan_mode)
        MODE_COMMENT: begin
          if (b == CH_BANG) scan_mode_next = MODE_IDLE;
        end
        MODE_INT, MODE_WORD: begin
          if (is_digit(b) || ((scan_mode == MODE_WORD) && (is_alpha(b) || b == CH_DOLLAR))) begin
            if (pending_length < 16'(KEYWORD_MAX_LEN)) begin
              word_chars_next[pending_length[IDX_W-1:0]] = b;
            end
            if (pending_length != 16'hffff) pending_length_next = pending_length + 16'd1;
          end else begin
            scan_fresh = 1'b1;
          end
        end
        MODE_IDLE: scan_fresh = 1'b1;
        default:   scan_fresh = 1'b1;
      endcase

      // byte seen as if idle, after any flush
      if (scan_fresh) begin
        valid_a        = flushing;
        scan_mode_next = MODE_IDLE;
        tok_b.first_char     = b;
        tok_b.start_position = byte_position;
        tok_b.token_length   = 16'd1;
        if (is_blank(b)) begin
          scan_mode_next = MODE_IDLE;
        end else if (b == CH_BANG) begin
          scan_mode_next = MODE_COMMENT;
        end else if (is_operator(b)) begin
          valid_b          = 1'b1;
          tok_b.token_kind = KIND_OPERATOR;
        end else if (is_separator(b)) begin
          valid_b          = 1'b1;
          tok_b.token_kind = KIND_SEPARATOR;
        end else begin
          scan_mode_next      = is_digit(b) ? MODE_INT : MODE_WORD;
          pending_start_next  = byte_position;
          pending_first_next  = b;
          pending_length_next = 16'd1;
          for (int j = 0; j < KEYWORD_MAX_LEN; j++) word_chars_next[j] = 8'h00;
          word_chars_next[0] = b;
        end
      end
    end

    // order the tokens, last flag on the final one
    tok_a.last_of_run = !valid_b;
    tok_b.last_of_run = 1'b1;
    new0 = valid_a ? tok_a : tok_b;
    new1 = tok_b;
  end

  // scanner registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode      <= MODE_IDLE;
      word_chars     <= '{default: 8'h00};
      pending_length <= '0;
      pending_start  <= '0;
      pending_first  <= '0;
      byte_position  <= '0;
    end else if (in_accept) begin
      scan_mode      <= scan_mode_next;
      word_chars     <= word_chars_next;
      pending_length <= pending_length_next;
      pending_start  <= pending_start_next;
      pending_first  <= pending_first_next;
      byte_position  <= byte_position_next;
    end
  end

  // result buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      res0_valid <= 1'b0;
      res1_valid <= 1'b0;
    end else if (in_accept) begin
      res0_valid <= valid_a || valid_b;
      res1_valid <= valid_a && valid_b;
    end else if (out_accept) begin
      res0_valid <= res1_valid;
      res1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      res0 <= new0;
      res1 <= new1;
    end else if (out_accept) begin
      res0 <= res1;
    end
  end

`ifndef SYNTHESIS
  // second slot is only ever filled behind the first
  a_slot_order: assert property (@(posedge clk) disable iff (rst)
    res1_valid |-> res0_valid)
    else $error("second result slot valid without the first");

  // a lone head token always closes its item, a waiting second one never
  a_last_single: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !res1_valid) |-> m_axis_tlast)
    else $error("lone buffered token not flagged last");

  a_last_pair: assert property (@(posedge clk) disable iff (rst)
    res1_valid |-> !m_axis_tlast)
    else $error("first of two tokens flagged last");

  // end of input leaves the scanner idle and takes no byte position
  a_eoi_idle: assert property (@(posedge clk) disable iff (rst)
    (in_accept && s_axis_tlast) |=> (scan_mode == MODE_IDLE) && $stable(byte_position))
    else $error("end of input did not settle the scanner");
`endif

endmodule

`default_nettype wire
